// ----- sv/cbfs_pkg.sv -----
package cbfs_pkg;

   localparam int CW = 10;
   localparam int BW = 8;
   localparam logic [CW-1:0] CAP_RESET = 10'd1023;

   typedef enum logic [1:0] {
      OP_PUSH     = 2'd0,
      OP_POP      = 2'd1,
      OP_FIND_FWD = 2'd2,
      OP_FIND_REV = 2'd3
   } cbfs_op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } cbfs_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_SEARCH
   } cbfs_state_type;

   typedef struct packed {
      cbfs_op_type     op;
      logic [BW-1:0]   data;
      logic            last;
   } cbfs_cmd_type;

   typedef struct packed {
      cbfs_status_type status;
      logic [BW-1:0]   data;
      logic [CW-1:0]   offset;
      logic [CW-1:0]   occupancy;
      logic            last;
   } cbfs_rsp_type;

endpackage

// ----- sv/circular_byte_fifo_with_search.sv -----
// Pushes, failed pushes and requests on an empty ring are answered straight from the idle state;
// a pop reads the store first, and a search compares the occupied bytes one at a time, forward
// from the oldest or in reverse from the newest; its offset always counts from the oldest byte.
// Pushes and failed requests are taken one per cycle while the result queue has room; a pop or
// a search holds the executor until its result is out, since the store has a single read port.
// Reset is synchronous: both queues empty, the ring empty and capacity back to 1023.
module circular_byte_fifo_with_search #(
   parameter int STORE_DEPTH = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_type,
   input  logic [7:0] req_data_byte,
   input  logic       req_burst_last,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_data_out,
   output logic [9:0] rsp_match_offset,
   output logic [9:0] rsp_occupancy,
   output logic       rsp_burst_end,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [9:0] csr_capacity_in_use
);

   import cbfs_pkg::*;

   cbfs_cmd_type cmd_data;
   logic         cmd_valid, cmd_take;
   cbfs_rsp_type res_data, out_data;
   logic         res_valid, res_full;

   assign csr_ready = 1'b1;

   cbfs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_type       (req_type),
      .req_data_byte  (req_data_byte),
      .req_burst_last (req_burst_last),
      .req_full       (req_full),
      .cmd_valid      (cmd_valid),
      .cmd_take       (cmd_take),
      .cmd_data       (cmd_data)
   );

   cbfs_back #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_capacity_in_use),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take),
      .res_full  (res_full),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   cbfs_queue #(
      .WIDTH ($bits(cbfs_rsp_type))
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (res_valid),
      .wr_data (res_data),
      .full    (res_full),
      .pop     (rsp_pop),
      .rd_data (out_data),
      .empty   (rsp_empty)
   );

   assign rsp_status       = out_data.status;
   assign rsp_data_out     = out_data.data;
   assign rsp_match_offset = out_data.offset;
   assign rsp_occupancy    = out_data.occupancy;
   assign rsp_burst_end    = out_data.last;

endmodule

// ----- sv/cbfs_ram.sv -----
module cbfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/cbfs_queue.sv -----
module cbfs_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_sel_ff, wr_sel_in;
   logic             rd_sel_ff, rd_sel_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_sel_ff];

   always_comb begin
      wr_sel_in = do_push ? !wr_sel_ff : wr_sel_ff;
      rd_sel_in = do_pop ? !rd_sel_ff : rd_sel_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_sel_ff <= 1'b0;
         rd_sel_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_sel_ff <= wr_sel_in;
         rd_sel_ff <= rd_sel_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_sel_ff] <= wr_data;
      end
   end

endmodule

// ----- sv/cbfs_front.sv -----
module cbfs_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic [1:0]            req_type,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_burst_last,
   output logic                  req_full,
   output logic                  cmd_valid,
   input  logic                  cmd_take,
   output cbfs_pkg::cbfs_cmd_type cmd_data
);

   import cbfs_pkg::*;

   cbfs_cmd_type cmd_word;
   logic         q_empty;

   // Every request code is meaningful, so decoding is a plain cast to the operation.
   assign cmd_word.op   = cbfs_op_type'(req_type);
   assign cmd_word.data = req_data_byte;
   assign cmd_word.last = req_burst_last;

   cbfs_queue #(
      .WIDTH($bits(cbfs_cmd_type))
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (cmd_word),
      .full    (req_full),
      .pop     (cmd_take),
      .rd_data (cmd_data),
      .empty   (q_empty)
   );

   assign cmd_valid = !q_empty;

endmodule

// ----- sv/cbfs_back.sv -----
module cbfs_back #(
   parameter int STORE_DEPTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [9:0]             csr_data,
   input  logic                   cmd_valid,
   input  cbfs_pkg::cbfs_cmd_type cmd_data,
   output logic                   cmd_take,
   input  logic                   res_full,
   output logic                   res_valid,
   output cbfs_pkg::cbfs_rsp_type res_data
);

   import cbfs_pkg::*;

   localparam int AW     = $clog2(STORE_DEPTH);
   localparam int CapMax = (STORE_DEPTH - 1 < 1023) ? STORE_DEPTH - 1 : 1023;

   function automatic logic [CW-1:0] clamp_cap(input logic [CW-1:0] raw);
      logic [CW-1:0] c;
      c = raw;
      if (raw == '0) begin
         c = CW'(1);
      end else if (32'(raw) > CapMax) begin
         c = CW'(CapMax);
      end
      return c;
   endfunction

   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx,
                                               input logic [AW-1:0] top);
      return (idx == top) ? '0 : idx + AW'(1);
   endfunction

   function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] idx,
                                               input logic [AW-1:0] top);
      return (idx == '0) ? top : idx - AW'(1);
   endfunction

   cbfs_state_type state_ff, state_in;
   logic [CW-1:0]  cap_ff, fill_ff, fill_in;
   logic [AW-1:0]  top_ff;
   logic [AW-1:0]  oldest_ff, oldest_in;
   logic [AW-1:0]  next_free_ff, next_free_in;
   logic [AW-1:0]  ptr_ff, ptr_in;
   logic [CW-1:0]  off_ff, off_in;
   logic [BW-1:0]  key_ff, key_in;
   logic           blast_ff, blast_in;
   logic           fwd_ff, fwd_in;

   logic           take;
   logic           hit, at_end;
   logic [AW-1:0]  newest;
   logic           ram_we;
   logic [AW-1:0]  ram_waddr, ram_raddr;
   logic [BW-1:0]  ram_rdata;

   cbfs_ram #(
      .WIDTH (BW),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (cmd_data.data),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign take   = (state_ff == S_IDLE) && cmd_valid && !res_full;
   assign hit    = (ram_rdata == key_ff);
   // The walk ends once the byte at the far end of the occupied span has been compared.
   assign at_end = fwd_ff ? (off_ff == fill_ff - CW'(1)) : (off_ff == '0);
   assign newest = ring_prev(next_free_ff, top_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (take && fill_ff != '0 && cmd_data.op == OP_POP) begin
               state_in = S_POP;
            end else if (take && fill_ff != '0 &&
                         (cmd_data.op == OP_FIND_FWD || cmd_data.op == OP_FIND_REV)) begin
               state_in = S_SEARCH;
            end
         end
         S_POP: begin
            state_in = S_IDLE;
         end
         S_SEARCH: begin
            if (hit || at_end) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      fill_in      = fill_ff;
      oldest_in    = oldest_ff;
      next_free_in = next_free_ff;
      ptr_in       = ptr_ff;
      off_in       = off_ff;
      key_in       = key_ff;
      blast_in     = blast_ff;
      fwd_in       = fwd_ff;
      cmd_take     = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = next_free_ff;
      ram_raddr    = ptr_ff;
      res_valid    = 1'b0;
      res_data     = '{status: ST_OK, data: '0, offset: '0, occupancy: fill_ff,
                       last: blast_ff};
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               cmd_take      = 1'b1;
               key_in        = cmd_data.data;
               blast_in      = cmd_data.last;
               fwd_in        = (cmd_data.op == OP_FIND_FWD);
               res_data.last = cmd_data.last;
               case (cmd_data.op)
                  OP_PUSH: begin
                     res_valid = 1'b1;
                     if (fill_ff >= cap_ff) begin
                        res_data.status = ST_FULL;
                     end else begin
                        ram_we             = 1'b1;
                        next_free_in       = ring_next(next_free_ff, top_ff);
                        fill_in            = fill_ff + CW'(1);
                        res_data.occupancy = fill_ff + CW'(1);
                     end
                  end
                  OP_POP: begin
                     ram_raddr = oldest_ff;
                     if (fill_ff == '0) begin
                        res_valid       = 1'b1;
                        res_data.status = ST_EMPTY;
                     end else begin
                        oldest_in = ring_next(oldest_ff, top_ff);
                        fill_in   = fill_ff - CW'(1);
                     end
                  end
                  OP_FIND_FWD: begin
                     ram_raddr = oldest_ff;
                     ptr_in    = ring_next(oldest_ff, top_ff);
                     off_in    = '0;
                     if (fill_ff == '0) begin
                        res_valid       = 1'b1;
                        res_data.status = ST_EMPTY;
                     end
                  end
                  OP_FIND_REV: begin
                     ram_raddr = newest;
                     ptr_in    = ring_prev(newest, top_ff);
                     off_in    = fill_ff - CW'(1);
                     if (fill_ff == '0) begin
                        res_valid       = 1'b1;
                        res_data.status = ST_EMPTY;
                     end
                  end
                  default: begin
                     res_valid = 1'b0;
                  end
               endcase
            end
         end
         S_POP: begin
            res_valid     = 1'b1;
            res_data.data = ram_rdata;
         end
         S_SEARCH: begin
            // One read is issued each cycle while the previous byte is compared.
            ptr_in = fwd_ff ? ring_next(ptr_ff, top_ff) : ring_prev(ptr_ff, top_ff);
            off_in = fwd_ff ? off_ff + CW'(1) : off_ff - CW'(1);
            if (hit) begin
               res_valid       = 1'b1;
               res_data.offset = off_ff;
            end else if (at_end) begin
               res_valid       = 1'b1;
               res_data.status = ST_NOT_FOUND;
            end
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= clamp_cap(CAP_RESET);
         top_ff       <= AW'(clamp_cap(CAP_RESET));
         fill_ff      <= '0;
         oldest_ff    <= '0;
         next_free_ff <= '0;
      end else if (csr_write) begin
         // A new capacity empties the ring; earlier bytes become unreachable.
         state_ff     <= S_IDLE;
         cap_ff       <= clamp_cap(csr_data);
         top_ff       <= AW'(clamp_cap(csr_data));
         fill_ff      <= '0;
         oldest_ff    <= '0;
         next_free_ff <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         next_free_ff <= next_free_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff   <= ptr_in;
      off_ff   <= off_in;
      key_ff   <= key_in;
      blast_ff <= blast_in;
      fwd_ff   <= fwd_in;
   end

endmodule

// ----- sv/cbfs_checker.sv -----
module cbfs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_data_out,
   input logic [9:0] rsp_match_offset,
   input logic [9:0] rsp_occupancy,
   input logic       rsp_burst_end
);

   import cbfs_pkg::*;

   // After reset both sides are open and nothing is waiting.
   assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // A request on an empty ring carries no byte and no offset.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_status == ST_EMPTY |->
         rsp_occupancy == 10'd0 && rsp_data_out == 8'd0 && rsp_match_offset == 10'd0)
      else $error("empty result carries data");

   // A match offset always lies inside the occupied span.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_match_offset != 10'd0 |->
         rsp_status == ST_OK && rsp_match_offset < rsp_occupancy && rsp_data_out == 8'd0)
      else $error("match offset outside the ring");

   // A waiting result stays put until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=>
         !rsp_empty && $stable(rsp_status) && $stable(rsp_data_out) &&
         $stable(rsp_match_offset) && $stable(rsp_occupancy) && $stable(rsp_burst_end))
      else $error("stalled result changed");

endmodule

bind circular_byte_fifo_with_search cbfs_checker u_checker (.*);

// ----- tb/circular_byte_fifo_with_search_tb.sv -----
module circular_byte_fifo_with_search_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cbfs_pkg::*;

   localparam int unsigned SWAP_AFTER   = 620;   // requests in the first idling regime
   localparam int unsigned QUIET_AFTER  = 1240;  // from here on neither side idles
   localparam int unsigned SETTLE_TICKS = 20;

   logic          clock;
   logic          reset = 1'b1;
   logic          req_push = 1'b0;
   logic          req_full;
   logic [1:0]    req_type = '0;
   logic [BW-1:0] req_data_byte = '0;
   logic          req_burst_last = 1'b0;
   logic          rsp_empty;
   logic          rsp_pop = 1'b0;
   logic [1:0]    rsp_status;
   logic [BW-1:0] rsp_data_out;
   logic [CW-1:0] rsp_match_offset;
   logic [CW-1:0] rsp_occupancy;
   logic          rsp_burst_end;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [CW-1:0] csr_capacity_in_use = '0;

   // Mirror of the ring held by the block.
   logic [BW-1:0] ring_bytes [0:1023];
   logic [CW-1:0] ring_cap;
   int unsigned   ring_head;
   int unsigned   ring_tail;
   int unsigned   ring_count;

   cbfs_cmd_type  queued_reqs [$];
   cbfs_rsp_type  awaited_rsps [$];
   logic          req_accepted = 1'b0;
   int unsigned   reqs_taken = 0;
   int unsigned   rsps_seen = 0;
   int unsigned   cap_writes = 0;
   int unsigned   status_seen [4] = '{0, 0, 0, 0};
   int unsigned   errors = 0;

   circular_byte_fifo_with_search u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_type            (req_type),
      .req_data_byte       (req_data_byte),
      .req_burst_last      (req_burst_last),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_status          (rsp_status),
      .rsp_data_out        (rsp_data_out),
      .rsp_match_offset    (rsp_match_offset),
      .rsp_occupancy       (rsp_occupancy),
      .rsp_burst_end       (rsp_burst_end),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_capacity_in_use (csr_capacity_in_use)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // A capacity of zero behaves as one; ten bits can never exceed the store.
   function automatic int unsigned usable_bytes();
      return (ring_cap == '0) ? 1 : int'(ring_cap);
   endfunction

   function automatic int unsigned ring_wrap(int unsigned idx);
      int unsigned slots;
      slots = usable_bytes() + 1;
      return (idx >= slots) ? idx - slots : idx;
   endfunction

   function automatic cbfs_rsp_type apply_request(cbfs_cmd_type cmd);
      cbfs_rsp_type r;
      int unsigned  i;
      int unsigned  pos;
      bit           found;
      r = '0;
      r.status = ST_OK;
      r.last = cmd.last;
      found = 1'b0;
      case (cmd.op)
         OP_PUSH: begin
            if (ring_count >= usable_bytes()) begin
               r.status = ST_FULL;
            end else begin
               ring_bytes[ring_tail] = cmd.data;
               ring_tail = ring_wrap(ring_tail + 1);
               ring_count++;
            end
         end
         OP_POP: begin
            if (ring_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.data = ring_bytes[ring_head];
               ring_head = ring_wrap(ring_head + 1);
               ring_count--;
            end
         end
         default: begin
            if (ring_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               // The forward search walks from the oldest byte, the reverse one from the newest.
               for (i = 0; i < ring_count; i++) begin
                  pos = (cmd.op == OP_FIND_FWD) ? i : ring_count - 1 - i;
                  if (!found && ring_bytes[ring_wrap(ring_head + pos)] == cmd.data) begin
                     found = 1'b1;
                     r.offset = CW'(pos);
                  end
               end
               if (!found) begin
                  r.status = ST_NOT_FOUND;
               end
            end
         end
      endcase
      r.occupancy = CW'(ring_count);
      return r;
   endfunction

   function automatic int unsigned sender_gap_pct();
      if (reqs_taken < SWAP_AFTER) return 26;
      if (reqs_taken < QUIET_AFTER) return 74;
      return 0;
   endfunction

   function automatic int unsigned receiver_gap_pct();
      if (reqs_taken < SWAP_AFTER) return 74;
      if (reqs_taken < QUIET_AFTER) return 26;
      return 0;
   endfunction

   task automatic check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         errors++;
      end
   endtask

   // Driver: a request is held until the monitor has seen it taken.
   always @(negedge clock) begin
      cbfs_cmd_type next_req;
      if (!reset) begin
         if (!req_push || req_accepted) begin
            if (queued_reqs.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct()) begin
               next_req = queued_reqs.pop_front();
               req_push <= 1'b1;
               req_type <= next_req.op;
               req_data_byte <= next_req.data;
               req_burst_last <= next_req.last;
            end else begin
               req_push <= 1'b0;
            end
         end
         rsp_pop <= ($urandom_range(0, 99) >= receiver_gap_pct());
      end
   end

   // Monitor: results are checked before the request of the same edge is predicted.
   always @(posedge clock) begin
      cbfs_rsp_type want;
      cbfs_cmd_type cmd;
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            rsps_seen++;
            status_seen[rsp_status]++;
            if (awaited_rsps.size() == 0) begin
               $display("%0t: result with no request outstanding, expected none, got status %0d",
                        $time, rsp_status);
               errors++;
            end else begin
               want = awaited_rsps.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("data_out", want.data, rsp_data_out);
               check_field("match_offset", want.offset, rsp_match_offset);
               check_field("occupancy", want.occupancy, rsp_occupancy);
               check_field("burst_end", want.last, rsp_burst_end);
            end
         end
         req_accepted <= req_push && !req_full;
         if (req_push && !req_full) begin
            cmd.op = cbfs_op_type'(req_type);
            cmd.data = req_data_byte;
            cmd.last = req_burst_last;
            awaited_rsps.push_back(apply_request(cmd));
            reqs_taken++;
         end
      end
   end

   task automatic queue_req(cbfs_op_type op, logic [BW-1:0] data, logic last);
      cbfs_cmd_type cmd;
      cmd.op = op;
      cmd.data = data;
      cmd.last = last;
      queued_reqs.push_back(cmd);
   endtask

   function automatic cbfs_op_type pick_search();
      return $urandom_range(0, 1) ? OP_FIND_FWD : OP_FIND_REV;
   endfunction

   // Half of the bytes come from a narrow range so that searches mostly hit.
   task automatic queue_random(int unsigned count, int unsigned push_pct, int unsigned pop_pct);
      int unsigned   roll;
      cbfs_op_type   op;
      logic [BW-1:0] data;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < push_pct) op = OP_PUSH;
         else if (roll < push_pct + pop_pct) op = OP_POP;
         else op = pick_search();
         data = $urandom_range(0, 1) ? BW'($urandom_range(0, 7)) : BW'($urandom_range(0, 255));
         queue_req(op, data, 1'($urandom_range(0, 1)));
      end
   endtask

   // Sampled on the rising edge, where the driven request lines are settled.
   task automatic wait_until_drained();
      while (queued_reqs.size() != 0 || req_push || awaited_rsps.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   task automatic write_capacity(logic [CW-1:0] value);
      wait_until_drained();
      csr_valid <= 1'b1;
      csr_capacity_in_use <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      // A capacity write empties the ring.
      ring_cap = value;
      ring_head = 0;
      ring_tail = 0;
      ring_count = 0;
      cap_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Fill the largest ring to the brim; the last byte that fits is the only 0xFF.
   task automatic queue_deep_fill();
      int unsigned i;
      for (i = 0; i < 1030; i++) begin
         queue_req(OP_PUSH, (i == 1022) ? 8'hFF : BW'($urandom_range(0, 254)),
                   1'($urandom_range(0, 1)));
         if (i % 64 == 63) begin
            queue_req(pick_search(), BW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
      end
      queue_req(OP_FIND_FWD, 8'hFF, 1'b1);
      queue_req(OP_FIND_REV, 8'hFF, 1'b0);
   endtask

   initial begin
      ring_cap = CAP_RESET;
      ring_head = 0;
      ring_tail = 0;
      ring_count = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset capacity: requests on an empty ring, then pushes, both searches and the pops.
      queue_req(OP_POP, 8'hFF, 1'b1);
      queue_req(OP_FIND_FWD, 8'h00, 1'b0);
      queue_req(OP_FIND_REV, 8'hFF, 1'b1);
      queue_req(OP_PUSH, 8'h00, 1'b0);
      queue_req(OP_PUSH, 8'hFF, 1'b1);
      queue_req(OP_PUSH, 8'h00, 1'b0);
      queue_req(OP_FIND_FWD, 8'h00, 1'b0);
      queue_req(OP_FIND_REV, 8'h00, 1'b1);
      queue_req(OP_FIND_FWD, 8'hA5, 1'b0);
      queue_req(OP_FIND_REV, 8'hFF, 1'b0);
      queue_req(OP_POP, 8'h00, 1'b0);
      queue_req(OP_POP, 8'h00, 1'b1);
      queue_req(OP_POP, 8'h00, 1'b0);
      queue_req(OP_POP, 8'h00, 1'b1);

      // Zero capacity holds a single byte.
      write_capacity(10'd0);
      queue_req(OP_PUSH, 8'h5A, 1'b0);
      queue_req(OP_PUSH, 8'hC3, 1'b1);
      queue_req(OP_FIND_REV, 8'h5A, 1'b0);
      queue_req(OP_POP, 8'h00, 1'b0);
      queue_req(OP_PUSH, 8'h11, 1'b1);

      // The write must discard the byte left behind.
      write_capacity(10'd2);
      queue_req(OP_POP, 8'h00, 1'b0);
      queue_req(OP_PUSH, 8'hFE, 1'b0);
      queue_req(OP_PUSH, 8'h01, 1'b1);
      queue_req(OP_PUSH, 8'h77, 1'b0);
      queue_req(OP_FIND_FWD, 8'h01, 1'b1);
      queue_req(OP_POP, 8'h00, 1'b0);
      queue_req(OP_PUSH, 8'h80, 1'b1);
      queue_req(OP_FIND_REV, 8'h80, 1'b0);
      queue_req(OP_FIND_FWD, 8'h01, 1'b1);

      write_capacity(10'd1);
      queue_random(50, 45, 35);
      write_capacity(10'd3);
      queue_random(150, 45, 30);
      write_capacity(10'd16);
      queue_random(100, 70, 15);
      queue_random(100, 20, 60);
      write_capacity(10'd1023);
      queue_deep_fill();
      queue_random(60, 20, 50);
      write_capacity(10'd31);
      queue_random(100, 60, 20);
      queue_random(100, 30, 50);
      write_capacity(10'd2);
      queue_random(100, 40, 35);

      wait_until_drained();
      $display("Ran %0d requests and checked %0d results over %0d capacity writes.",
               reqs_taken, rsps_seen, cap_writes);
      $display("Statuses seen: ok %0d, full %0d, empty %0d, not found %0d.",
               status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
               status_seen[ST_NOT_FOUND]);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/cbfs_pkg.sv
sv/cbfs_ram.sv
sv/cbfs_queue.sv
sv/cbfs_front.sv
sv/cbfs_back.sv
sv/circular_byte_fifo_with_search.sv
sv/cbfs_checker.sv
tb/circular_byte_fifo_with_search_tb.sv
